### hdl/ptw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, constants and index helpers of the four-level page walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int MEM_WORDS   = 65536;
   localparam int MEM_AW      = $clog2(MEM_WORDS);
   localparam int WORD_W      = 64;
   localparam int PADDR_W     = 52;
   localparam int INDEX_W     = 16;
   localparam int LEVEL_BITS  = 9;
   localparam int TOP_SHIFT   = 39;
   localparam int PAGE_SHIFT  = 12;
   localparam int PRESENT_POS = 0;
   localparam int LARGE_POS   = 7;

   localparam logic [1:0] LAST_LEVEL = 2'd3;

   localparam logic [PADDR_W-1:0] FRAME_MASK =
      {{(PADDR_W-PAGE_SHIFT){1'b1}}, {PAGE_SHIFT{1'b0}}};

   typedef enum logic [1:0] {
      ACT_WRITE     = 2'd0,
      ACT_READ      = 2'd1,
      ACT_TRANSLATE = 2'd2,
      ACT_NONE      = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_WALK = 3'b100
   } state_type;

   function automatic logic [5:0] level_shift(input logic [1:0] lvl);
      logic [5:0] sh;
      case (lvl)
         2'd0:    sh = 6'(TOP_SHIFT);
         2'd1:    sh = 6'(TOP_SHIFT - LEVEL_BITS);
         2'd2:    sh = 6'(TOP_SHIFT - 2 * LEVEL_BITS);
         default: sh = 6'(PAGE_SHIFT);
      endcase
      return sh;
   endfunction

   function automatic logic [MEM_AW-1:0] table_word(input logic [PADDR_W-1:0] base,
                                                    input logic [WORD_W-1:0]  va,
                                                    input logic [1:0]         lvl);
      logic [WORD_W-1:0] sv;
      sv = va >> level_shift(lvl);
      return base[MEM_AW+2:3] + MEM_AW'(sv[LEVEL_BITS-1:0]);
   endfunction

endpackage
`default_nettype wire

### hdl/page_table_walker.sv
// Write and unused action answer in the cycle after the accept. A read passes the
// registered memory output and S_READ. A translate issues the top-level table read in
// the accept cycle, then S_WALK takes each level as a dependent read through the
// single memory read port. Throughput: one item at a time; busy holds until the
// result cycle, where the next item may be accepted; the receiver cannot stall results.
// Reset clears control state and the root register; memory stays undefined until written.
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_walker
// Word memory with write, read and a four-level page table walk that returns
// the physical address or a fault and the covering virtual region.
// ----------------------------------------------------------------------------
module page_table_walker import ptw_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_action,
   input  wire logic [INDEX_W-1:0]   req_word_index,
   input  wire logic [WORD_W-1:0]    req_write_word,
   input  wire logic [WORD_W-1:0]    req_vaddr,
   output logic                      rsp_valid,
   output logic [WORD_W-1:0]         rsp_read_word,
   output logic [PADDR_W-1:0]        rsp_phys_addr,
   output logic                      rsp_fault,
   output logic [WORD_W-1:0]         rsp_region_start,
   output logic [WORD_W-1:0]         rsp_region_end,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [PADDR_W-1:0]   csr_data
);

   logic [WORD_W-1:0] phys_memory [MEM_WORDS];
   logic [WORD_W-1:0] mem_q_ff;
   logic [MEM_AW-1:0] rd_addr;
   logic              mem_we;

   state_type         state_ff, state_in;
   logic [1:0]        level_ff, level_in;
   logic [WORD_W-1:0] va_ff, va_in;
   logic [PADDR_W-1:0] root_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_read_word_ff, rsp_read_word_in;
   logic [PADDR_W-1:0] rsp_phys_addr_ff, rsp_phys_addr_in;
   logic              rsp_fault_ff, rsp_fault_in;
   logic [WORD_W-1:0] rsp_start_ff, rsp_start_in;
   logic [WORD_W-1:0] rsp_end_ff, rsp_end_in;

   logic              accept;
   logic [PADDR_W-1:0] entry;
   logic [WORD_W-1:0] span_mask;
   logic [WORD_W-1:0] reg_start;
   logic              walk_stop;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign entry     = mem_q_ff[PADDR_W-1:0];
   assign span_mask = (WORD_W'(1) << level_shift(level_ff)) - WORD_W'(1);
   assign reg_start = va_ff & ~span_mask;
   assign walk_stop = (level_ff == LAST_LEVEL) || entry[LARGE_POS] || !entry[PRESENT_POS];
   assign mem_we    = accept && (req_action == ACT_WRITE);

   always_comb begin
      state_in         = state_ff;
      level_in         = level_ff;
      va_in            = va_ff;
      rd_addr          = MEM_AW'(req_word_index);
      rsp_valid_in     = 1'b0;
      rsp_read_word_in = '0;
      rsp_phys_addr_in = '0;
      rsp_fault_in     = 1'b0;
      rsp_start_in     = '0;
      rsp_end_in       = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_READ: begin
                     state_in = S_READ;
                  end
                  ACT_TRANSLATE: begin
                     state_in = S_WALK;
                     level_in = 2'd0;
                     va_in    = req_vaddr;
                     rd_addr  = table_word(root_ff, req_vaddr, 2'd0);
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_read_word_in = mem_q_ff;
            state_in         = S_IDLE;
         end
         S_WALK: begin
            if (walk_stop) begin
               rsp_valid_in = 1'b1;
               rsp_start_in = reg_start;
               rsp_end_in   = reg_start + span_mask + WORD_W'(1);
               rsp_fault_in = !entry[PRESENT_POS];
               if (entry[PRESENT_POS]) begin
                  rsp_phys_addr_in = (entry & ~span_mask[PADDR_W-1:0]) |
                                     (va_ff[PADDR_W-1:0] & span_mask[PADDR_W-1:0]);
               end
               state_in = S_IDLE;
            end else begin
               level_in = level_ff + 2'd1;
               rd_addr  = table_word(entry & FRAME_MASK, va_ff, level_ff + 2'd1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         phys_memory[MEM_AW'(req_word_index)] <= req_write_word;
      end
      mem_q_ff <= phys_memory[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            root_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      va_ff    <= va_in;
      if (rsp_valid_in) begin
         rsp_read_word_ff <= rsp_read_word_in;
         rsp_phys_addr_ff <= rsp_phys_addr_in;
         rsp_fault_ff     <= rsp_fault_in;
         rsp_start_ff     <= rsp_start_in;
         rsp_end_ff       <= rsp_end_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_word    = rsp_read_word_ff;
   assign rsp_phys_addr    = rsp_phys_addr_ff;
   assign rsp_fault        = rsp_fault_ff;
   assign rsp_region_start = rsp_start_ff;
   assign rsp_region_end   = rsp_end_ff;

endmodule
`default_nettype wire

### hdl/ptw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks of the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
module ptw_checker import ptw_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic [1:0]           req_action,
   input wire logic                 rsp_valid,
   input wire logic [WORD_W-1:0]    rsp_read_word,
   input wire logic [PADDR_W-1:0]   rsp_phys_addr,
   input wire logic                 rsp_fault,
   input wire logic [WORD_W-1:0]    rsp_region_start,
   input wire logic [WORD_W-1:0]    rsp_region_end
);

   a_write_word_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACT_WRITE || req_action == ACT_NONE) |=> rsp_valid)
      else $error("write or unused word without result on next cycle");

   a_translate_holds_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACT_TRANSLATE) |=> busy && !rsp_valid)
      else $error("translate did not hold busy");

   a_fault_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_phys_addr == '0 && rsp_read_word == '0)
      else $error("fault word carries an address");

   a_region_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phys_addr != '0 || rsp_fault) |-> rsp_region_end != rsp_region_start)
      else $error("translation word with empty region");

   a_read_no_region: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_word != '0 |-> rsp_region_start == '0 && rsp_region_end == '0)
      else $error("read word carries a region");

endmodule

bind page_table_walker ptw_checker u_ptw_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_action       (req_action),
   .rsp_valid        (rsp_valid),
   .rsp_read_word    (rsp_read_word),
   .rsp_phys_addr    (rsp_phys_addr),
   .rsp_fault        (rsp_fault),
   .rsp_region_start (rsp_region_start),
   .rsp_region_end   (rsp_region_end)
);
`default_nettype wire

### verif/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for page_table_walker: memory writes, reads and
// four-level translations are predicted and compared field by field.
// ----------------------------------------------------------------------------
module tb;
   import ptw_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQUESTS = 570;
   localparam logic [WORD_W-1:0] ENTRY_MASK64 = {12'h000, {PADDR_W{1'b1}}};
   localparam logic [PADDR_W-1:0] ROOT_MAX = 52'hF_FFFF_FFFF_F000;

   typedef struct packed {
      logic [WORD_W-1:0]  read_word;
      logic [PADDR_W-1:0] phys_addr;
      logic               fault;
      logic [WORD_W-1:0]  region_start;
      logic [WORD_W-1:0]  region_end;
   } walk_result_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_action;
   logic [INDEX_W-1:0] req_word_index;
   logic [WORD_W-1:0] req_write_word;
   logic [WORD_W-1:0] req_vaddr;
   logic rsp_valid;
   logic [WORD_W-1:0] rsp_read_word;
   logic [PADDR_W-1:0] rsp_phys_addr;
   logic rsp_fault;
   logic [WORD_W-1:0] rsp_region_start;
   logic [WORD_W-1:0] rsp_region_end;
   logic csr_valid;
   logic csr_ready;
   logic [PADDR_W-1:0] csr_data;

   logic [WORD_W-1:0] mem_image [int unsigned];
   int unsigned written_words[$];
   logic [WORD_W-1:0] recent_vaddrs[$];
   logic [PADDR_W-1:0] root_model;
   walk_result_type expected_results[$];
   int errors = 0;
   int requests_sent = 0;
   int gap_limit = 9;
   int cycle_count = 0;

   page_table_walker uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_word_index(req_word_index),
      .req_write_word(req_write_word),
      .req_vaddr(req_vaddr),
      .rsp_valid(rsp_valid),
      .rsp_read_word(rsp_read_word),
      .rsp_phys_addr(rsp_phys_addr),
      .rsp_fault(rsp_fault),
      .rsp_region_start(rsp_region_start),
      .rsp_region_end(rsp_region_end),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Walk from root_model; returns 0 with the missing word when a fetch hits
   // a word that was never written.
   function automatic bit walk_table(input logic [WORD_W-1:0] va,
                                     output walk_result_type res,
                                     output int unsigned gap_word,
                                     output int gap_level);
      logic [PADDR_W-1:0] base;
      logic [WORD_W-1:0] entry;
      logic [WORD_W-1:0] mask;
      logic [MEM_AW-1:0] w;
      int shift;
      res = '0;
      gap_word = 0;
      gap_level = 0;
      base = root_model;
      for (int lvl = 0; lvl < 4; lvl++) begin
         shift = TOP_SHIFT - LEVEL_BITS * lvl;
         w = base[MEM_AW+2:3] + MEM_AW'((va >> shift) & 64'd511);
         if (!mem_image.exists(int'(w))) begin
            gap_word = 32'(w);
            gap_level = lvl;
            return 1'b0;
         end
         entry = mem_image[int'(w)] & ENTRY_MASK64;
         mask = (64'd1 << shift) - 64'd1;
         if (lvl == 3 || entry[LARGE_POS] || !entry[PRESENT_POS]) begin
            res.region_start = va & ~mask;
            res.region_end = res.region_start + mask + 64'd1;
            res.fault = !entry[PRESENT_POS];
            res.phys_addr = entry[PRESENT_POS] ?
                            PADDR_W'((entry & ~mask) + (va & mask)) : '0;
            return 1'b1;
         end
         base = entry[PADDR_W-1:0] & FRAME_MASK;
      end
      return 1'b1;
   endfunction

   function automatic walk_result_type predict_response(input action_type act,
                                                        input logic [INDEX_W-1:0] widx,
                                                        input logic [WORD_W-1:0] wdata,
                                                        input logic [WORD_W-1:0] va);
      walk_result_type r;
      int unsigned gw;
      int gl;
      r = '0;
      case (act)
         ACT_WRITE: begin
            if (!mem_image.exists(int'(widx)))
               written_words.push_back(32'(widx));
            mem_image[int'(widx)] = wdata;
         end
         ACT_READ: begin
            if (mem_image.exists(int'(widx)))
               r.read_word = mem_image[int'(widx)];
         end
         ACT_TRANSLATE: begin
            void'(walk_table(va, r, gw, gl));
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] make_entry(input int lvl);
      logic [WORD_W-1:0] e;
      e = rand64();
      e[PRESENT_POS] = ($urandom_range(0, 9) != 0);
      if (lvl < 3)
         e[LARGE_POS] = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) != 0)
         e[18:12] = 7'($urandom_range(0, 15));
      return e;
   endfunction

   function automatic logic [WORD_W-1:0] pick_vaddr();
      logic [WORD_W-1:0] m;
      int keep;
      if (recent_vaddrs.size() > 0 && $urandom_range(0, 9) < 6) begin
         keep = PAGE_SHIFT + LEVEL_BITS * $urandom_range(0, 3);
         m = (64'd1 << keep) - 64'd1;
         return (recent_vaddrs[$urandom_range(0, recent_vaddrs.size() - 1)] & ~m) |
                (rand64() & m);
      end
      return rand64();
   endfunction

   task automatic send_item(input action_type act, input logic [INDEX_W-1:0] widx,
                            input logic [WORD_W-1:0] wdata,
                            input logic [WORD_W-1:0] va);
      int gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_word_index <= widx;
      req_write_word <= wdata;
      req_vaddr <= va;
      do @(posedge clock); while (busy !== 1'b0);
      expected_results.push_back(predict_response(act, widx, wdata, va));
      if (act != ACT_NONE)
         requests_sent++;
   endtask

   task automatic hold_requests();
      start <= 1'b0;
   endtask

   task automatic drain();
      hold_requests();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_root(input logic [PADDR_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      root_model = value;
   endtask

   // Fill missing table entries along the path, then translate.
   task automatic run_translation(input logic [WORD_W-1:0] va);
      walk_result_type r;
      int unsigned gw;
      int gl;
      while (!walk_table(va, r, gw, gl))
         send_item(ACT_WRITE, INDEX_W'(gw), make_entry(gl), rand64());
      send_item(ACT_TRANSLATE, INDEX_W'($urandom), rand64(), va);
      recent_vaddrs.push_back(va);
      if (recent_vaddrs.size() > 32)
         void'(recent_vaddrs.pop_front());
   endtask

   task automatic test_memory_words();
      gap_limit = 9;
      send_item(ACT_WRITE, 16'h0000, 64'h0, rand64());
      send_item(ACT_WRITE, 16'hFFFF, '1, rand64());
      send_item(ACT_WRITE, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, rand64());
      send_item(ACT_READ, 16'hFFFF, rand64(), rand64());
      send_item(ACT_READ, 16'h0000, rand64(), rand64());
      send_item(ACT_READ, 16'h5555, rand64(), rand64());
      send_item(ACT_NONE, 16'hFFFF, '1, '1);
   endtask

   task automatic test_walk_cases();
      gap_limit = 0;
      send_item(ACT_TRANSLATE, 16'h0, 64'h0, 64'h0);
      write_root(52'h1000);
      send_item(ACT_WRITE, 16'd512, 64'h0000_0000_0000_2023, 64'h0);
      send_item(ACT_WRITE, 16'd1024, 64'h0000_0000_0000_3001, 64'h0);
      send_item(ACT_WRITE, 16'd1536, 64'h0000_0000_0000_4001, 64'h0);
      send_item(ACT_WRITE, 16'd2048, 64'hFFFF_FFFF_FFFF_F0FF, 64'h0);
      send_item(ACT_TRANSLATE, 16'h0, 64'h0, 64'h0000_0000_0000_0ABC);
      send_item(ACT_WRITE, 16'd1025, 64'h0000_0000_4000_0081, 64'h0);
      send_item(ACT_TRANSLATE, 16'h0, 64'h0, 64'h0000_0000_5234_5678);
      send_item(ACT_WRITE, 16'd1537, 64'h8000_0000_0060_0081, 64'h0);
      send_item(ACT_TRANSLATE, 16'h0, 64'h0, 64'h0000_0000_0030_0042);
      gap_limit = 9;
      send_item(ACT_WRITE, 16'd2049, 64'h0000_0000_0000_F0FE, 64'h0);
      send_item(ACT_TRANSLATE, 16'h0, 64'h0, 64'h0000_0000_0000_1000);
      send_item(ACT_WRITE, 16'd1538, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0);
      send_item(ACT_TRANSLATE, 16'h0, 64'h0, 64'h0000_0000_0040_0000);
      send_item(ACT_WRITE, 16'd1023, 64'hFFFF_8000_0000_0081, 64'h0);
      send_item(ACT_TRANSLATE, 16'h0, 64'h0, '1);
      write_root(52'h1005);
      send_item(ACT_TRANSLATE, 16'h0, 64'h0, 64'h0000_0000_0000_0ABC);
      write_root(ROOT_MAX);
      send_item(ACT_WRITE, 16'd65024, 64'h0000_0000_0000_0081, 64'h0);
      send_item(ACT_TRANSLATE, 16'h0, 64'h0, 64'h0000_007F_FFFF_FFFF);
   endtask

   task automatic test_random_traffic();
      logic [PADDR_W-1:0] root;
      int sel;
      int target;
      for (int phase = 0; phase < 4; phase++) begin
         root = PADDR_W'(rand64()) & FRAME_MASK;
         case (phase)
            1: root = '0;
            2: root = {1'b0, root[PADDR_W-2:12], 12'($urandom)};
            3: root = ROOT_MAX;
            default: ;
         endcase
         write_root(root);
         target = requests_sent + RANDOM_REQUESTS / 4;
         while (requests_sent < target) begin
            if ($urandom_range(0, 49) == 0)
               gap_limit = ($urandom_range(0, 2) == 0) ? 0 : 9;
            sel = $urandom_range(0, 99);
            if (sel < 50)
               run_translation(pick_vaddr());
            else if (sel < 70)
               send_item(ACT_READ,
                         INDEX_W'(written_words[$urandom_range(0, written_words.size() - 1)]),
                         rand64(), rand64());
            else if (sel < 95)
               send_item(ACT_WRITE, INDEX_W'($urandom), rand64(), rand64());
            else
               send_item(ACT_NONE, INDEX_W'($urandom), rand64(), rand64());
         end
      end
   endtask

   always @(posedge clock) begin
      walk_result_type exp;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: read_word %h phys_addr %h fault %b",
                        rsp_read_word, rsp_phys_addr, rsp_fault);
         end else begin
            exp = expected_results.pop_front();
            if (rsp_read_word !== exp.read_word || rsp_phys_addr !== exp.phys_addr ||
                rsp_fault !== exp.fault || rsp_region_start !== exp.region_start ||
                rsp_region_end !== exp.region_end) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: read_word %h/%h phys_addr %h/%h fault %b/%b",
                            " start %h/%h end %h/%h"},
                           exp.read_word, rsp_read_word, exp.phys_addr, rsp_phys_addr,
                           exp.fault, rsp_fault, exp.region_start, rsp_region_start,
                           exp.region_end, rsp_region_end);
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_action <= ACT_NONE;
      req_word_index <= '0;
      req_write_word <= '0;
      req_vaddr <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      root_model = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_memory_words();
      test_walk_cases();
      test_random_traffic();
      drain();
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
hdl/ptw_pkg.sv
hdl/page_table_walker.sv
hdl/ptw_checker.sv
verif/tb.sv
